>>> src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`timescale 1ns / 1ps

package spq_pkg;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } spq_op_t;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 32;
    localparam int COUNT_W = 5;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // an enqueue taken this cycle into a queue that is not full
        logic remove;  // a dequeue taken this cycle from a queue that is not empty
    } spq_ctrl_t;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted chain: holds a value and its key and trades them
// with its neighbors on insert and remove. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic                     aclk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic [VALUE_W-1:0]       new_value,
    input  logic signed [PRIO_W-1:0] new_priority,
    input  logic                     left_le,
    input  logic [VALUE_W-1:0]       left_value,
    input  logic signed [PRIO_W-1:0] left_priority,
    input  logic [VALUE_W-1:0]       right_value,
    input  logic signed [PRIO_W-1:0] right_priority,
    output logic                     own_le,
    output logic [VALUE_W-1:0]       value_out,
    output logic signed [PRIO_W-1:0] priority_out,
    output logic [VALUE_W-1:0]       value_next,
    output logic signed [PRIO_W-1:0] priority_next
);

    logic [VALUE_W-1:0]       value_reg;
    logic signed [PRIO_W-1:0] priority_reg;

    // The new entry goes behind every held entry whose key is not larger.
    assign own_le       = occupied && (priority_reg <= new_priority);
    assign value_out    = value_reg;
    assign priority_out = priority_reg;

    // Keep, take the new entry, or shift from a neighbor.
    always_comb begin
        value_next    = value_reg;
        priority_next = priority_reg;
        priority if (ctrl.insert) begin
            priority if (own_le) begin
                value_next    = value_reg;
                priority_next = priority_reg;
            end else if (left_le) begin
                value_next    = new_value;
                priority_next = new_priority;
            end else begin
                value_next    = left_value;
                priority_next = left_priority;
            end
        end else if (ctrl.remove) begin
            value_next    = right_value;
            priority_next = right_priority;
        end
    end

    // Slot storage; its contents only matter below the occupancy count.
    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

endmodule

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots,
// the occupancy counter and the result register. Depends on spq_pkg, spq_cell.
`timescale 1ns / 1ps

// Usage:
//   Requests arrive on the s_ channel (valid/ready): s_opcode selects
//   enqueue, dequeue of the front entry, or clear. Each request yields
//   exactly one result on the m_ channel (valid/ready) with the removed
//   value, a status, the entry count and the front entry after the request.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken. All slots
//   compare the new key in parallel and shift toward or away from the front
//   in the same cycle, so the slot chain never holds back a request.
//   A new request is accepted while the held result is being taken; when
//   the receiver stalls, the result register holds and s_ready drops.
//   Enqueue into a full queue and dequeue from an empty queue leave the
//   queue unchanged and are flagged in m_status.
//   Reset (aresetn low, synchronous) empties the queue and drops m_valid;
//   slot contents are not cleared, since only occupied slots are read.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [VALUE_W-1:0]        s_item_value,
    input  logic signed [PRIO_W-1:0]  s_item_priority,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [VALUE_W-1:0]        m_removed_value,
    output logic [1:0]                m_status,
    output logic [COUNT_W-1:0]        m_entry_count,
    output logic                      m_front_valid,
    output logic [VALUE_W-1:0]        m_front_value,
    output logic signed [PRIO_W-1:0]  m_front_priority
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [VALUE_W-1:0]       removed_reg;
    logic [1:0]               status_reg;
    logic [COUNT_W-1:0]       entry_count_reg;
    logic                     front_valid_reg;
    logic [VALUE_W-1:0]       front_value_reg;
    logic signed [PRIO_W-1:0] front_priority_reg;

    logic      accept;
    spq_op_t   op;
    logic      is_full, is_empty;
    spq_ctrl_t ctrl;
    logic [1:0] status_next;

    logic                     cell_le       [QUEUE_DEPTH];
    logic [VALUE_W-1:0]       cell_value    [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] cell_priority [QUEUE_DEPTH];
    logic [VALUE_W-1:0]       cell_vnext    [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] cell_pnext    [QUEUE_DEPTH];

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign op       = spq_op_t'(s_opcode);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the request into chain control, status and the new count.
    always_comb begin
        ctrl        = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        unique case (op)
            OP_ENQUEUE: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.insert = accept;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DEQUEUE: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    ctrl.remove = accept;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_NOP: begin
                count_next = count_reg;
            end
        endcase
    end

    // The slot chain; slot 0 is the front.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                     left_le;
        logic [VALUE_W-1:0]       left_value;
        logic signed [PRIO_W-1:0] left_priority;
        logic [VALUE_W-1:0]       right_value;
        logic signed [PRIO_W-1:0] right_priority;
        logic                     occupied;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_le       = 1'b1;
            assign left_value    = s_item_value;
            assign left_priority = s_item_priority;
        end else begin : g_body
            assign left_le       = cell_le[i-1];
            assign left_value    = cell_value[i-1];
            assign left_priority = cell_priority[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_value    = cell_value[i];
            assign right_priority = cell_priority[i];
        end else begin : g_inner
            assign right_value    = cell_value[i+1];
            assign right_priority = cell_priority[i+1];
        end

        spq_cell u_cell (
            .aclk           (aclk),
            .ctrl           (ctrl),
            .occupied       (occupied),
            .new_value      (s_item_value),
            .new_priority   (s_item_priority),
            .left_le        (left_le),
            .left_value     (left_value),
            .left_priority  (left_priority),
            .right_value    (right_value),
            .right_priority (right_priority),
            .own_le         (cell_le[i]),
            .value_out      (cell_value[i]),
            .priority_out   (cell_priority[i]),
            .value_next     (cell_vnext[i]),
            .priority_next  (cell_pnext[i])
        );
    end

    // Occupancy and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            removed_reg     <= ctrl.remove ? cell_value[0] : '0;
            status_reg      <= status_next;
            entry_count_reg <= COUNT_W'(count_next);
            front_valid_reg <= (count_next != '0);
            front_value_reg    <= (count_next != '0) ? cell_vnext[0] : '0;
            front_priority_reg <= (count_next != '0) ? cell_pnext[0] : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_removed_value  = removed_reg;
    assign m_status         = status_reg;
    assign m_entry_count    = entry_count_reg;
    assign m_front_valid    = front_valid_reg;
    assign m_front_value    = front_value_reg;
    assign m_front_priority = front_priority_reg;

`ifndef NO_ASSERTIONS
    // The count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    // Without an accepted request the count holds.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("occupancy changed without a request");

    // A held result reports the current front presence.
    a_front_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (front_valid_reg == (count_reg != '0)))
        else $error("front valid disagrees with occupancy");

    // A full status is only reported while the queue is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_FULL) |-> is_full)
        else $error("full status with free slots");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for sorted_priority_queue: a directed table, then random requests.
// Each result is checked against a predictor of the sorted queue. Depends on spq_pkg.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 1150;
    localparam int SEGMENT_LEN = 50;

    // One result as the block reports it.
    typedef struct packed {
        logic [VALUE_W-1:0]       removed_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     front_valid;
        logic [VALUE_W-1:0]       front_value;
        logic signed [PRIO_W-1:0] front_priority;
    } queue_result_t;

    // One row of the directed table; fixed_result is used only when has_fixed is set.
    typedef struct packed {
        spq_op_t                  op;
        logic [VALUE_W-1:0]       value;
        logic signed [PRIO_W-1:0] key;
        logic                     has_fixed;
        queue_result_t            fixed_result;
    } request_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_opcode = OP_NOP;
    logic [VALUE_W-1:0]        s_item_value = '0;
    logic signed [PRIO_W-1:0]  s_item_priority = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [VALUE_W-1:0]        m_removed_value;
    logic [1:0]                m_status;
    logic [COUNT_W-1:0]        m_entry_count;
    logic                      m_front_valid;
    logic [VALUE_W-1:0]        m_front_value;
    logic signed [PRIO_W-1:0]  m_front_priority;

    // Predicted queue contents, front at index 0.
    logic [VALUE_W-1:0]        held_value [DEPTH];
    logic signed [PRIO_W-1:0]  held_key [DEPTH];
    int                        held_count = 0;

    queue_result_t             pending_results[$];
    request_row_t              directed_rows[$];
    int                        mismatch_count = 0;
    int                        send_gap_max = 8;
    int                        drain_gap_max = 8;

    sorted_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_entry_count   (m_entry_count),
        .m_front_valid   (m_front_valid),
        .m_front_value   (m_front_value),
        .m_front_priority(m_front_priority)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one request to the predicted queue and return the result it should produce.
    function automatic queue_result_t apply_request(spq_op_t op, logic [VALUE_W-1:0] value,
                                                    logic signed [PRIO_W-1:0] key);
        queue_result_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQUEUE: begin
                if (held_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // A new entry goes behind every entry with an equal or smaller key.
                    pos = 0;
                    while (pos < held_count && held_key[pos] <= key)
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_value[i] = held_value[i-1];
                        held_key[i] = held_key[i-1];
                    end
                    held_value[pos] = value;
                    held_key[pos] = key;
                    held_count++;
                end
            end
            OP_DEQUEUE: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed_value = held_value[0];
                    for (int i = 1; i < held_count; i++) begin
                        held_value[i-1] = held_value[i];
                        held_key[i-1] = held_key[i];
                    end
                    held_count--;
                end
            end
            OP_CLEAR: held_count = 0;
            default: ;
        endcase
        r.entry_count = held_count[COUNT_W-1:0];
        r.front_valid = (held_count > 0);
        if (held_count > 0) begin
            r.front_value = held_value[0];
            r.front_priority = held_key[0];
        end
        return r;
    endfunction

    // Builds a result for the typed-in rows of the directed table.
    function automatic queue_result_t make_result(logic [VALUE_W-1:0] removed, logic [1:0] status,
                                                  logic [COUNT_W-1:0] count, logic fvalid,
                                                  logic [VALUE_W-1:0] fvalue,
                                                  logic signed [PRIO_W-1:0] fkey);
        queue_result_t r;
        r.removed_value = removed;
        r.status = status;
        r.entry_count = count;
        r.front_valid = fvalid;
        r.front_value = fvalue;
        r.front_priority = fkey;
        return r;
    endfunction

    task automatic add_row(spq_op_t op, logic [VALUE_W-1:0] value, logic [PRIO_W-1:0] key,
                           logic has_fixed, queue_result_t fixed_result);
        request_row_t row;
        row.op = op;
        row.value = value;
        row.key = key;
        row.has_fixed = has_fixed;
        row.fixed_result = fixed_result;
        directed_rows.push_back(row);
    endtask

    // Keys lean toward extremes and a few small Q16.16 integers so that ties are common.
    function automatic logic [PRIO_W-1:0] draw_key();
        logic [PRIO_W-1:0] k;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: k = 32'h8000_0000;
                    1: k = 32'h7FFF_FFFF;
                    2: k = 32'h0000_0000;
                    default: k = 32'hFFFF_FFFF;
                endcase
            end
            1, 2: k = ($urandom_range(0, 7) - 4) << 16;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Drive one request at the falling edge after a random gap, wait for it to be
    // accepted, then queue its expected result.
    task automatic send_request(spq_op_t op, logic [VALUE_W-1:0] value,
                                logic [PRIO_W-1:0] key, logic has_fixed,
                                queue_result_t fixed_result);
        int gap;
        queue_result_t predicted;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_item_value <= value;
        s_item_priority <= key;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        predicted = apply_request(op, value, key);
        pending_results.push_back(has_fixed ? fixed_result : predicted);
    endtask

    function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            mismatch_count++;
            $error("%s: expected %h, actual %h", name, expected, actual);
        end
    endfunction

    // Result side: random stalls on m_ready, every accepted result checked in order.
    initial begin : result_drain
        int gap;
        queue_result_t exp;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, drain_gap_max);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1)
                @(posedge aclk);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result with no request waiting");
            end else begin
                exp = pending_results.pop_front();
                check_field("removed_value", exp.removed_value, m_removed_value);
                check_field("status", exp.status, m_status);
                check_field("entry_count", exp.entry_count, m_entry_count);
                check_field("front_valid", exp.front_valid, m_front_valid);
                check_field("front_value", exp.front_value, m_front_value);
                check_field("front_priority", exp.front_priority, m_front_priority);
            end
        end
    end

    // Request side: reset, the directed table, then random segments.
    initial begin : request_feed
        queue_result_t none;
        queue_result_t zeros;
        request_row_t row;
        int enq_weight;
        int pick;
        spq_op_t op;
        none = '0;
        zeros = make_result(32'h0, ST_OK, 5'd0, 1'b0, 32'h0, 32'h0);

        // Empty queue: dequeue, no-op and clear.
        add_row(OP_DEQUEUE, 32'h1234_5678, 32'h0000_0001, 1'b1,
                make_result(32'h0, ST_EMPTY, 5'd0, 1'b0, 32'h0, 32'h0));
        add_row(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, zeros);
        add_row(OP_CLEAR, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, zeros);
        // Insert into an empty queue, then ahead of the head.
        add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                make_result(32'h0, ST_OK, 5'd1, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        add_row(OP_ENQUEUE, 32'h0000_0000, 32'h8000_0000, 1'b1,
                make_result(32'h0, ST_OK, 5'd2, 1'b1, 32'h0000_0000, 32'h8000_0000));
        // Fill to the top with ties, negatives and both extremes.
        add_row(OP_ENQUEUE, 32'h0000_0001, 32'h8000_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h5A5A_5A5A, 32'hFFFF_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0002, 32'h0000_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0003, 32'h7FFF_FFFF, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0004, 32'h0001_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h0000_8000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0005, 32'h7FFF_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0006, 32'h8000_0001, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0007, 32'h0000_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0008, 32'hC000_0000, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_0009, 32'h3FFF_FFFF, 1'b0, none);
        add_row(OP_ENQUEUE, 32'h0000_000A, 32'hFFFF_0000, 1'b0, none);
        // Full queue refuses the enqueue and is left as it was.
        add_row(OP_ENQUEUE, 32'hDEAD_BEEF, 32'h8000_0000, 1'b1,
                make_result(32'h0, ST_FULL, 5'd16, 1'b1, 32'h0000_0000, 32'h8000_0000));
        add_row(OP_NOP, 32'h0, 32'h0, 1'b0, none);
        // Equal keys leave in arrival order.
        add_row(OP_DEQUEUE, 32'h0, 32'h0, 1'b0, none);
        add_row(OP_DEQUEUE, 32'h0, 32'h0, 1'b0, none);
        // Clear a loaded queue, then dequeue from it.
        add_row(OP_CLEAR, 32'h0, 32'h0, 1'b1, zeros);
        add_row(OP_DEQUEUE, 32'h0, 32'h0, 1'b1,
                make_result(32'h0, ST_EMPTY, 5'd0, 1'b0, 32'h0, 32'h0));

        // Synchronous reset held, then released at a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.op, row.value, row.key, row.has_fixed, row.fixed_result);
        end

        // Random segments, each with its own enqueue bias and idling pattern.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                case ($urandom_range(0, 3))
                    0: enq_weight = 35;
                    1: enq_weight = 50;
                    2: enq_weight = 65;
                    default: enq_weight = 80;
                endcase
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
                drain_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            pick = $urandom_range(0, 99);
            if (pick < enq_weight)
                op = OP_ENQUEUE;
            else if (pick < 96)
                op = OP_DEQUEUE;
            else if (pick < 98)
                op = OP_CLEAR;
            else
                op = OP_NOP;
            send_request(op, $urandom, draw_key(), 1'b0, none);
        end

        // Drain the remaining results, then keep the drain running to catch stray ones.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
